FILE: rtl/arrive_steering_controller_unit_assert.svh
// Assertion macros shared by the arrive steering controller RTL.
`ifndef ARRIVE_STEERING_CONTROLLER_UNIT_ASSERT_SVH
`define ARRIVE_STEERING_CONTROLLER_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
// Check a property on every rising clock edge outside reset.
`define ASC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("asc assertion failed");
// Check that a condition implies a consequence in the same cycle.
`define ASC_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("asc implication failed");
`else
`define ASC_ASSERT(lbl, clk, rst_n, prop)
`define ASC_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`endif
`endif

FILE: rtl/asc_pkg.sv
// Types, codes and constants shared by the arrive steering controller modules.
`timescale 1ns / 1ps
`default_nettype none
package asc_pkg;

    localparam int REG_W      = 31;
    localparam int ANG_STEPS  = 18;
    localparam int ROOT_STEPS = 32;
    localparam int DIV_STEPS  = 31;
    localparam int CNT_W      = 5;
    localparam int ANG_W      = 18;
    localparam int IDX_W      = 8;

    localparam logic [IDX_W-1:0] REG_SPEED    = 8'd0;
    localparam logic [IDX_W-1:0] REG_DEADZONE = 8'd1;
    localparam logic [IDX_W-1:0] REG_SLOWDOWN = 8'd2;

    localparam logic [REG_W-1:0] SPEED_RST    = 31'd65536;
    localparam logic [REG_W-1:0] DEADZONE_RST = 31'd655;
    localparam logic [REG_W-1:0] SLOWDOWN_RST = 31'd32768;

    localparam logic MODE_TARGET = 1'b0;
    localparam logic MODE_TICK   = 1'b1;

    typedef enum logic [4:0] {
        ST_IDLE, ST_LOAD, ST_CHECK, ST_SHIFT, ST_SQX, ST_SQY, ST_SQD,
        ST_ROOT_INIT, ST_ROOT, ST_DIV_INIT, ST_DIV, ST_DIV_STORE,
        ST_CORD_INIT, ST_NORM, ST_ROT, ST_HEAD, ST_PUBLISH
    } state_t;

    typedef enum logic [4:0] {
        OP_NONE, OP_SET_GOAL, OP_SET_POS, OP_LOAD, OP_ARRIVE, OP_SHR,
        OP_SQX, OP_SQY, OP_SQD, OP_ROOT_INIT, OP_ROOT_STEP, OP_DIV_INIT,
        OP_DIV_STEP, OP_DIV_STORE, OP_CORD_INIT, OP_NORM, OP_ROT, OP_HEAD,
        OP_PUBLISH
    } op_t;

    typedef struct packed {
        op_t              op;
        logic             axis;
        logic [CNT_W-1:0] step;
    } cmd_t;

    typedef struct packed {
        logic near;
        logic big;
        logic norm_done;
    } status_t;

    // Rotation angles atan(2^-i) in 1/16 binary-angle units
    function automatic logic [ANG_W-1:0] ang_lookup(input logic [CNT_W-1:0] i);
        logic [ANG_W-1:0] a;
        begin
            case (i)
                5'd0:    a = 18'd131072;
                5'd1:    a = 18'd77376;
                5'd2:    a = 18'd40884;
                5'd3:    a = 18'd20753;
                5'd4:    a = 18'd10417;
                5'd5:    a = 18'd5213;
                5'd6:    a = 18'd2607;
                5'd7:    a = 18'd1304;
                5'd8:    a = 18'd652;
                5'd9:    a = 18'd326;
                5'd10:   a = 18'd163;
                5'd11:   a = 18'd81;
                5'd12:   a = 18'd41;
                5'd13:   a = 18'd20;
                5'd14:   a = 18'd10;
                5'd15:   a = 18'd5;
                5'd16:   a = 18'd3;
                5'd17:   a = 18'd1;
                default: a = 18'd0;
            endcase
            return a;
        end
    endfunction

endpackage
`default_nettype wire

FILE: rtl/arrive_steering_controller_unit.sv
// Arrive steering controller: top level joining controller and datapath.
// An armed tick runs 32 square-root steps, two divisions, up to 30 normalize shifts and 18
// rotation steps before publishing its result. An arrival publishes zero velocity with
// arrived set after the load and check; a target request or a disarmed tick gives none.
// One request in flight; a waiting result adds its stall.
// Reset (aresetn low, synchronous) restores default registers, goal at origin, disarmed.
`timescale 1ns / 1ps
`default_nettype none
module arrive_steering_controller_unit
    import asc_pkg::*;
#(
    parameter int COORD_BITS = 32
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [127:0]      s_tdata,   // target_x, target_y, pos_x, pos_y
    input  wire logic              s_tuser,   // mode
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic      [79:0]       m_tdata,   // vel_x, vel_y, heading
    output logic      [1:0]        m_tuser,   // heading_valid, arrived
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [IDX_W-1:0]  cfg_index,
    input  wire logic [31:0]       cfg_data
);

    cmd_t    cmd;
    status_t status;

    assign cfg_ready = 1'b1;

    asc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    asc_datapath #(
        .COORD_BITS (COORD_BITS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule
`default_nettype wire

FILE: rtl/asc_datapath.sv
// Datapath: goal/config storage, magnitude, square root, divider, angle rotation.
`timescale 1ns / 1ps
`default_nettype none
module asc_datapath
    import asc_pkg::*;
#(
    parameter int COORD_BITS = 32
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire cmd_t              cmd,
    output status_t                status,
    input  wire logic              cfg_we,
    input  wire logic [IDX_W-1:0]  cfg_index,
    input  wire logic [31:0]       cfg_data,
    input  wire logic [127:0]      s_tdata,
    output logic      [79:0]       m_tdata,
    output logic      [1:0]        m_tuser
);

    localparam int MAGW = (COORD_BITS + 1 > 32) ? COORD_BITS + 1 : 32;

    logic [REG_W-1:0] speed_reg, deadzone_reg, slowdown_reg;
    logic signed [COORD_BITS-1:0] goal_x_reg, goal_y_reg, pos_x_reg, pos_y_reg;
    logic [MAGW-1:0] mag_x_reg, mag_y_reg;
    logic neg_x_reg, neg_y_reg, shifted_reg, inside_reg;
    logic [61:0] acc_reg, sd2_reg;
    logic [62:0] sum_reg, rv_reg, rbit_reg;
    logic [63:0] rr_reg;
    logic [31:0] drem_reg;
    logic [30:0] dlow_reg, quo_reg;
    logic [33:0] cx_reg, cy_reg;
    logic [18:0] z_reg;
    logic [31:0] res_vx_reg, res_vy_reg;
    logic [15:0] res_head_reg;
    logic res_hv_reg, res_arr_reg;
    logic [79:0] out_data_reg;
    logic [1:0]  out_user_reg;

    logic signed [MAGW:0] dx_w, dy_w;
    logic [30:0] mx_w, my_w, mult_a_w, mult_b_w;
    logic [61:0] mult_w;
    logic [63:0] rtry_w;
    logic [31:0] den_w, vel_w;
    logic [32:0] dtry_w;
    logic        dge_w;
    logic [33:0] xs_w, ys_w;
    logic [15:0] q_w, a_w;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            speed_reg    <= SPEED_RST;
            deadzone_reg <= DEADZONE_RST;
            slowdown_reg <= SLOWDOWN_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_SPEED:    speed_reg    <= cfg_data[REG_W-1:0];
                REG_DEADZONE: deadzone_reg <= cfg_data[REG_W-1:0];
                REG_SLOWDOWN: slowdown_reg <= cfg_data[REG_W-1:0];
                default: ;
            endcase
        end
    end

    // Goal is control state and resets to the origin
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            goal_x_reg <= '0;
            goal_y_reg <= '0;
        end else if (cmd.op == OP_SET_GOAL) begin
            goal_x_reg <= COORD_BITS'(signed'(s_tdata[31:0]));
            goal_y_reg <= COORD_BITS'(signed'(s_tdata[63:32]));
        end
    end

    // Exact axis differences
    assign dx_w = (MAGW+1)'(goal_x_reg) - (MAGW+1)'(pos_x_reg);
    assign dy_w = (MAGW+1)'(goal_y_reg) - (MAGW+1)'(pos_y_reg);
    assign mx_w = mag_x_reg[30:0];
    assign my_w = mag_y_reg[30:0];

    // Shared multiplier operand selection
    always_comb begin
        mult_a_w = mx_w;
        mult_b_w = mx_w;
        case (cmd.op)
            OP_SQY: begin
                mult_a_w = my_w;
                mult_b_w = my_w;
            end
            OP_SQD: begin
                mult_a_w = slowdown_reg;
                mult_b_w = slowdown_reg;
            end
            OP_DIV_INIT: begin
                mult_a_w = cmd.axis ? my_w : mx_w;
                mult_b_w = speed_reg;
            end
            default: ;
        endcase
    end
    assign mult_w = 62'(mult_a_w) * 62'(mult_b_w);

    assign rtry_w = rr_reg + {1'b0, rbit_reg};
    assign den_w  = inside_reg ? {1'b0, slowdown_reg} : rr_reg[31:0];
    assign dtry_w = {drem_reg, dlow_reg[30]};
    assign dge_w  = dtry_w >= {1'b0, den_w};
    assign vel_w  = (cmd.axis ? neg_y_reg : neg_x_reg) ? 32'(-{1'b0, quo_reg})
                                                      : {1'b0, quo_reg};
    assign xs_w   = cx_reg >> cmd.step;
    assign ys_w   = cy_reg >> cmd.step;

    // Quadrant fold of the first-quadrant angle
    always_comb begin
        q_w = 16'((20'(z_reg) + 20'd8) >> 4);
        if (!neg_y_reg)
            a_w = neg_x_reg ? 16'(-q_w) : q_w;
        else
            a_w = neg_x_reg ? 16'(-(16'h8000 - q_w)) : 16'(16'h8000 - q_w);
    end

    // Working registers, advanced by command
    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_SET_POS: begin
                pos_x_reg <= COORD_BITS'(signed'(s_tdata[95:64]));
                pos_y_reg <= COORD_BITS'(signed'(s_tdata[127:96]));
            end
            OP_LOAD: begin
                mag_x_reg   <= dx_w[MAGW] ? MAGW'(-dx_w) : MAGW'(dx_w);
                mag_y_reg   <= dy_w[MAGW] ? MAGW'(-dy_w) : MAGW'(dy_w);
                neg_x_reg   <= dx_w[MAGW];
                neg_y_reg   <= dy_w[MAGW];
                shifted_reg <= 1'b0;
            end
            OP_SHR: begin
                mag_x_reg   <= mag_x_reg >> 1;
                mag_y_reg   <= mag_y_reg >> 1;
                shifted_reg <= 1'b1;
            end
            OP_SQX: acc_reg <= mult_w;
            OP_SQY: sum_reg <= {1'b0, acc_reg} + {1'b0, mult_w};
            OP_SQD: sd2_reg <= mult_w;
            OP_ROOT_INIT: begin
                inside_reg <= !shifted_reg && (sum_reg < {1'b0, sd2_reg});
                rv_reg     <= sum_reg;
                rr_reg     <= '0;
                rbit_reg   <= {1'b1, 62'd0};
            end
            OP_ROOT_STEP: begin
                if ({1'b0, rv_reg} >= rtry_w) begin
                    rv_reg <= rv_reg - rtry_w[62:0];
                    rr_reg <= (rr_reg >> 1) + {1'b0, rbit_reg};
                end else begin
                    rr_reg <= rr_reg >> 1;
                end
                rbit_reg <= rbit_reg >> 2;
            end
            OP_DIV_INIT: begin
                drem_reg <= {1'b0, mult_w[61:31]};
                dlow_reg <= mult_w[30:0];
                quo_reg  <= '0;
            end
            OP_DIV_STEP: begin
                drem_reg <= dge_w ? 32'(dtry_w - {1'b0, den_w}) : dtry_w[31:0];
                dlow_reg <= {dlow_reg[29:0], 1'b0};
                quo_reg  <= {quo_reg[29:0], dge_w};
            end
            OP_DIV_STORE: begin
                if (cmd.axis)
                    res_vy_reg <= vel_w;
                else
                    res_vx_reg <= vel_w;
            end
            OP_CORD_INIT: begin
                cx_reg <= 34'(my_w);
                cy_reg <= 34'(mx_w);
                z_reg  <= '0;
            end
            OP_NORM: begin
                cx_reg <= cx_reg << 1;
                cy_reg <= cy_reg << 1;
            end
            OP_ROT: begin
                if (cy_reg >= xs_w) begin
                    cy_reg <= cy_reg - xs_w;
                    cx_reg <= cx_reg + ys_w;
                    z_reg  <= z_reg + 19'(ang_lookup(cmd.step));
                end
            end
            OP_HEAD: begin
                res_head_reg <= 16'(-a_w);
                res_hv_reg   <= 1'b1;
                res_arr_reg  <= 1'b0;
            end
            OP_ARRIVE: begin
                res_vx_reg   <= '0;
                res_vy_reg   <= '0;
                res_head_reg <= '0;
                res_hv_reg   <= 1'b0;
                res_arr_reg  <= 1'b1;
            end
            OP_PUBLISH: begin
                out_data_reg <= {res_head_reg, res_vy_reg, res_vx_reg};
                out_user_reg <= {res_arr_reg, res_hv_reg};
            end
            default: ;
        endcase
    end

    // Status toward the controller
    assign status.near = !(mag_x_reg > MAGW'(deadzone_reg) ||
                           mag_y_reg > MAGW'(deadzone_reg));
    assign status.big  = (|mag_x_reg[MAGW-1:31]) || (|mag_y_reg[MAGW-1:31]);
    assign status.norm_done = (|cx_reg[33:30]) || (|cy_reg[33:30]);

    assign m_tdata = out_data_reg;
    assign m_tuser = out_user_reg;

endmodule
`default_nettype wire

FILE: rtl/asc_ctrl.sv
// Controller: sequences one request through the datapath and owns the handshakes.
`timescale 1ns / 1ps
`default_nettype none
`include "arrive_steering_controller_unit_assert.svh"
module asc_ctrl
    import asc_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    s_tvalid,
    input  wire logic    s_tuser,
    output logic         s_tready,
    output logic         m_tvalid,
    input  wire logic    m_tready,
    input  wire status_t status,
    output cmd_t         cmd
);

    state_t state_reg, state_next;
    logic moving_reg, moving_next;
    logic axis_reg, axis_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic out_valid_reg, out_valid_next;
    logic publish_ok;

    assign publish_ok = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            moving_reg    <= 1'b0;
            axis_reg      <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            moving_reg    <= moving_next;
            axis_reg      <= axis_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state
    always_comb begin
        state_next     = state_reg;
        moving_next    = moving_reg;
        axis_next      = axis_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        if (m_tready)
            out_valid_next = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (s_tuser == MODE_TARGET)
                        moving_next = 1'b1;
                    else if (moving_reg)
                        state_next = ST_LOAD;
                end
            end
            ST_LOAD:  state_next = ST_CHECK;
            ST_CHECK: begin
                if (status.near) begin
                    moving_next = 1'b0;
                    state_next  = ST_PUBLISH;
                end else begin
                    state_next = ST_SHIFT;
                end
            end
            ST_SHIFT: if (!status.big) state_next = ST_SQX;
            ST_SQX:   state_next = ST_SQY;
            ST_SQY:   state_next = ST_SQD;
            ST_SQD:   state_next = ST_ROOT_INIT;
            ST_ROOT_INIT: begin
                cnt_next   = '0;
                state_next = ST_ROOT;
            end
            ST_ROOT: begin
                if (cnt_reg == CNT_W'(ROOT_STEPS - 1)) begin
                    axis_next  = 1'b0;
                    state_next = ST_DIV_INIT;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_DIV_INIT: begin
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                    state_next = ST_DIV_STORE;
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            ST_DIV_STORE: begin
                if (!axis_reg) begin
                    axis_next  = 1'b1;
                    state_next = ST_DIV_INIT;
                end else begin
                    state_next = ST_CORD_INIT;
                end
            end
            ST_CORD_INIT: state_next = ST_NORM;
            ST_NORM: begin
                if (status.norm_done) begin
                    cnt_next   = '0;
                    state_next = ST_ROT;
                end
            end
            ST_ROT: begin
                if (cnt_reg == CNT_W'(ANG_STEPS - 1))
                    state_next = ST_HEAD;
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            ST_HEAD: state_next = ST_PUBLISH;
            ST_PUBLISH: begin
                if (publish_ok) begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Commands and handshake outputs
    always_comb begin
        cmd.op   = OP_NONE;
        cmd.axis = axis_reg;
        cmd.step = cnt_reg;
        s_tready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid)
                    cmd.op = (s_tuser == MODE_TARGET) ? OP_SET_GOAL : OP_SET_POS;
            end
            ST_LOAD:      cmd.op = OP_LOAD;
            ST_CHECK:     if (status.near) cmd.op = OP_ARRIVE;
            ST_SHIFT:     if (status.big) cmd.op = OP_SHR;
            ST_SQX:       cmd.op = OP_SQX;
            ST_SQY:       cmd.op = OP_SQY;
            ST_SQD:       cmd.op = OP_SQD;
            ST_ROOT_INIT: cmd.op = OP_ROOT_INIT;
            ST_ROOT:      cmd.op = OP_ROOT_STEP;
            ST_DIV_INIT:  cmd.op = OP_DIV_INIT;
            ST_DIV:       cmd.op = OP_DIV_STEP;
            ST_DIV_STORE: cmd.op = OP_DIV_STORE;
            ST_CORD_INIT: cmd.op = OP_CORD_INIT;
            ST_NORM:      if (!status.norm_done) cmd.op = OP_NORM;
            ST_ROT:       cmd.op = OP_ROT;
            ST_HEAD:      cmd.op = OP_HEAD;
            ST_PUBLISH:   if (publish_ok) cmd.op = OP_PUBLISH;
            default:      cmd.op = OP_NONE;
        endcase
    end

    assign m_tvalid = out_valid_reg;

    // Publishing never overwrites a result still waiting downstream
    `ASC_ASSERT_IMPLY(a_publish_free, aclk, aresetn, cmd.op == OP_PUBLISH, !out_valid_reg || m_tready)
    // Movement disarms only on an arrival check
    `ASC_ASSERT(a_disarm_on_arrive, aclk, aresetn, $fell(moving_reg) |-> $past(state_reg == ST_CHECK))
    // An armed tick starts the computation
    `ASC_ASSERT(a_tick_starts, aclk, aresetn, (s_tvalid && s_tready && s_tuser == MODE_TICK && moving_reg) |=> state_reg == ST_LOAD)

endmodule
`default_nettype wire
